### sv/slipfd_pkg.sv
package slipfd_pkg;

    localparam int MaxFrame = 512;
    localparam int LEN_W    = 10;

    localparam logic [LEN_W-1:0] MAX_FRAME_LEN = LEN_W'(MaxFrame);

    localparam logic [7:0] DELIM     = 8'hc0;
    localparam logic [7:0] ESC_BYTE  = 8'hdb;
    localparam logic [7:0] ESC_DELIM = 8'hdc;
    localparam logic [7:0] ESC_ESC   = 8'hdd;
    localparam logic [7:0] SUM_GOOD  = 8'hff;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD      = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] frame_length;
    } res_t;

endpackage

### sv/slipfd_decode.sv
module slipfd_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    output slipfd_pkg::res_t   res
);
    import slipfd_pkg::*;

    logic [LEN_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic             escape_pending_reg, escape_pending_next;
    logic [7:0]       decoded;

    always_comb begin
        byte_count_next     = byte_count_reg;
        running_sum_next    = running_sum_reg;
        escape_pending_next = escape_pending_reg;
        res_valid           = 1'b0;
        res.kind            = KIND_DATA;
        res.data_byte       = 8'd0;
        res.frame_length    = byte_count_reg;

        if (escape_pending_reg && rx_byte == ESC_DELIM) begin
            decoded = DELIM;
        end else if (escape_pending_reg && rx_byte == ESC_ESC) begin
            decoded = ESC_BYTE;
        end else begin
            decoded = rx_byte;
        end

        if (rx_byte == DELIM) begin
            res_valid           = (byte_count_reg != '0);
            res.kind            = (running_sum_reg == SUM_GOOD) ? KIND_GOOD : KIND_BAD;
            byte_count_next     = '0;
            running_sum_next    = 8'd0;
            escape_pending_next = 1'b0;
        end else if (rx_byte == ESC_BYTE) begin
            escape_pending_next = 1'b1;
        end else if (byte_count_reg >= MAX_FRAME_LEN) begin
            // drop the byte and restart framing
            res_valid           = 1'b1;
            res.kind            = KIND_OVERFLOW;
            res.frame_length    = MAX_FRAME_LEN;
            byte_count_next     = '0;
            running_sum_next    = 8'd0;
            escape_pending_next = 1'b0;
        end else begin
            res_valid           = 1'b1;
            res.data_byte       = decoded;
            byte_count_next     = byte_count_reg + 1'b1;
            res.frame_length    = byte_count_next;
            running_sum_next    = running_sum_reg + decoded;
            escape_pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg     <= '0;
            running_sum_reg    <= 8'd0;
            escape_pending_reg <= 1'b0;
        end else if (accept) begin
            byte_count_reg     <= byte_count_next;
            running_sum_reg    <= running_sum_next;
            escape_pending_reg <= escape_pending_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= MAX_FRAME_LEN)
        else $error("frame count beyond maximum");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && rx_byte == DELIM |=> byte_count_reg == '0 && running_sum_reg == 8'd0
            && !escape_pending_reg)
        else $error("delimiter did not clear frame state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_valid && res.kind == KIND_DATA
            |=> byte_count_reg == $past(byte_count_reg) + 1'b1)
        else $error("data word did not advance the count");
`endif

endmodule

### sv/slip_frame_decoder_with_checksum_core.sv
// SLIP deframer with an 8-bit additive checksum.
//
// Input channel s_*: one received link byte per word on s_rx_byte. Each
// byte is decoded at the edge it is accepted; escape and framing state is
// updated there. Data bytes, frame-good, checksum-bad and overflow reports
// leave on the m_* channel as m_kind, m_data_byte and m_frame_length.
// Escape bytes and empty frames produce no output word.
//
// Each result is registered. Throughput: one byte per cycle while
// s_ready is high, set by the single decode stage between the input
// handshake and the output register.
//
// A two-entry output buffer (output register plus skid register) lets the
// block keep accepting while m_ready is low; s_ready drops only once the
// skid register holds a word, and rises when the receiver drains it.
//
// Reset (aresetn low, synchronous) clears the frame count, sum, escape
// flag and both output entries; no output word survives reset.
module slip_frame_decoder_with_checksum_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [9:0] m_frame_length
);
    import slipfd_pkg::*;

    logic accept;
    logic res_valid;
    res_t res;

    logic out_valid_reg;
    res_t out_reg;
    logic skid_valid_reg;
    res_t skid_reg;
    logic load_out;

    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign load_out = !out_valid_reg || m_ready;

    slipfd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (load_out) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (accept && res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_data_byte    = out_reg.data_byte;
    assign m_frame_length = out_reg.frame_length;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_DATA |-> m_data_byte == 8'd0)
        else $error("report word carries data");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_OVERFLOW |-> m_frame_length == MAX_FRAME_LEN)
        else $error("overflow word with wrong length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_ready |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid entry lost while stalled");
`endif

endmodule

### tb/sv/slip_frame_decoder_with_checksum_core_tb.sv
`timescale 1ns / 1ps

module slip_frame_decoder_with_checksum_core_tb;
    import slipfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 1400;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 300;

    typedef struct {
        logic [7:0] rx;
        bit         drain_first;
    } link_word_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_data_byte;
    logic [9:0] m_frame_length;

    link_word_t link_bytes_q[$];
    res_t       expected_words_q[$];

    logic [LEN_W-1:0] frame_count = '0;
    logic [7:0]       frame_sum = '0;
    bit               esc_armed = 1'b0;

    int   results_due = 0;
    int   results_seen = 0;
    int   cycle_count = 0;
    int   send_gap = 0;
    int   recv_stall = 0;
    int   hold_left = 0;
    int   stall_draw;
    bit   long_hold_done = 1'b0;
    bit   send_burst = 1'b0;
    bit   recv_burst = 1'b0;
    bit   fail_seen = 1'b0;
    res_t exp_word;

    slip_frame_decoder_with_checksum_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_frame_length (m_frame_length)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    task automatic deframe_link_byte(input logic [7:0] rx);
        logic [7:0] dec;
        res_t       w;
        w.data_byte = '0;
        if (rx == DELIM) begin
            if (frame_count != 0) begin
                w.kind = (frame_sum == SUM_GOOD) ? KIND_GOOD : KIND_BAD;
                w.frame_length = frame_count;
                expected_words_q.push_back(w);
                results_due++;
            end
            frame_count = '0;
            frame_sum = '0;
            esc_armed = 1'b0;
        end else if (rx == ESC_BYTE) begin
            esc_armed = 1'b1;
        end else begin
            dec = rx;
            if (esc_armed && rx == ESC_DELIM) begin
                dec = DELIM;
            end else if (esc_armed && rx == ESC_ESC) begin
                dec = ESC_BYTE;
            end
            esc_armed = 1'b0;
            if (frame_count >= MAX_FRAME_LEN) begin
                w.kind = KIND_OVERFLOW;
                w.frame_length = MAX_FRAME_LEN;
                frame_count = '0;
                frame_sum = '0;
            end else begin
                frame_count = frame_count + 1'b1;
                frame_sum = frame_sum + dec;
                w.kind = KIND_DATA;
                w.data_byte = dec;
                w.frame_length = frame_count;
            end
            expected_words_q.push_back(w);
            results_due++;
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input bit drain);
        link_word_t item;
        item.rx = b;
        item.drain_first = drain;
        link_bytes_q.push_back(item);
    endtask

    task automatic add_escaped(input logic [7:0] b);
        bit drain;
        drain = ($urandom_range(0, 59) == 0);
        if (b == DELIM) begin
            add_byte(ESC_BYTE, drain);
            add_byte(ESC_DELIM, 1'b0);
        end else if (b == ESC_BYTE) begin
            add_byte(ESC_BYTE, drain);
            add_byte(ESC_ESC, 1'b0);
        end else begin
            add_byte(b, drain);
        end
    endtask

    function automatic logic [7:0] pick_link_byte();
        case ($urandom_range(0, 7))
            0: return DELIM;
            1: return ESC_BYTE;
            2: return ESC_DELIM;
            3: return ESC_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // body of n decoded bytes, the last one being the checksum
    task automatic add_frame_body(input int n_decoded, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] check;
        sum = '0;
        for (int i = 0; i < n_decoded - 1; i++) begin
            b = pick_link_byte();
            sum = sum + b;
            add_escaped(b);
        end
        check = SUM_GOOD - sum;
        if (corrupt) begin
            check = check ^ 8'($urandom_range(1, 255));
        end
        add_escaped(check);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                deframe_link_byte(s_rx_byte);
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (link_bytes_q.size() != 0 &&
                        (!link_bytes_q[0].drain_first || results_due == results_seen)) begin
                    s_rx_byte <= link_bytes_q[0].rx;
                    s_valid <= 1'b1;
                    link_bytes_q.delete(0);
                    if ($urandom_range(0, 39) == 0) begin
                        send_burst = !send_burst;
                    end
                    send_gap <= send_burst ? 0 : $urandom_range(0, 11);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_words_q.size() == 0) begin
                    fail_seen = 1'b1;
                    $display("%0t: word with none expected: kind %0d data %h length %0d",
                             $time, m_kind, m_data_byte, m_frame_length);
                end else begin
                    exp_word = expected_words_q.pop_front();
                    if (m_kind !== exp_word.kind) begin
                        fail_seen = 1'b1;
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, exp_word.kind, m_kind);
                    end
                    if (m_data_byte !== exp_word.data_byte) begin
                        fail_seen = 1'b1;
                        $display("%0t: data_byte expected %h actual %h",
                                 $time, exp_word.data_byte, m_data_byte);
                    end
                    if (m_frame_length !== exp_word.frame_length) begin
                        fail_seen = 1'b1;
                        $display("%0t: frame_length expected %0d actual %0d",
                                 $time, exp_word.frame_length, m_frame_length);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                hold_left <= LONG_HOLD;
                long_hold_done <= 1'b1;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                if ($urandom_range(0, 39) == 0) begin
                    recv_burst = !recv_burst;
                end
                stall_draw = recv_burst ? 0 : $urandom_range(0, 11);
                m_ready <= (stall_draw == 0);
                recv_stall <= (stall_draw == 0) ? 0 : stall_draw - 1;
            end else if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("slip_frame_decoder_with_checksum_core: mismatch");
            $finish;
        end
    end

    initial begin
        int pick;
        int n;

        add_byte(DELIM, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(DELIM, 1'b0);
        add_byte(ESC_BYTE, 1'b0);
        add_byte(ESC_BYTE, 1'b0);
        add_byte(ESC_DELIM, 1'b0);
        add_byte(ESC_BYTE, 1'b0);
        add_byte(ESC_ESC, 1'b0);
        add_byte(ESC_BYTE, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(ESC_DELIM, 1'b0);
        add_byte(ESC_ESC, 1'b0);
        add_byte(DELIM, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(ESC_BYTE, 1'b0);
        add_byte(DELIM, 1'b0);
        add_byte(ESC_ESC, 1'b0);
        add_byte(8'h7f, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(DELIM, 1'b0);

        // full-length frame, then an escape that stores nothing
        add_byte(8'h12, 1'b1);
        add_frame_body(MaxFrame - 1, 1'b0);
        add_byte(ESC_BYTE, 1'b0);
        add_byte(DELIM, 1'b0);

        // full-length frame, then one byte too many
        add_frame_body(MaxFrame, 1'b1);
        add_byte(8'h33, 1'b0);

        add_byte(DELIM, 1'b1);
        while (link_bytes_q.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            n = $urandom_range(1, 12);
            if (pick < 65) begin
                add_frame_body(n, 1'b0);
                add_byte(DELIM, 1'b0);
            end else if (pick < 80) begin
                add_frame_body(n, 1'b1);
                add_byte(DELIM, 1'b0);
            end else if (pick < 88) begin
                add_byte(DELIM, 1'b0);
            end else begin
                for (int i = 0; i < n / 2 + 1; i++) begin
                    add_byte(pick_link_byte(), 1'b0);
                end
            end
        end
        add_byte(DELIM, 1'b0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (link_bytes_q.size() != 0 || s_valid || results_seen != results_due) begin
            @(negedge aclk);
        end
        repeat (16) @(negedge aclk);
        if (expected_words_q.size() != 0) begin
            fail_seen = 1'b1;
            $display("%0t: %0d expected words never arrived", $time, expected_words_q.size());
        end
        if (!fail_seen) begin
            $display("slip_frame_decoder_with_checksum_core: match");
        end else begin
            $display("slip_frame_decoder_with_checksum_core: mismatch");
        end
        $finish;
    end

endmodule
